>>> sv/gph_pkg.sv
package gph_pkg;

  // Default sizes of the bin store.
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_COUNT_BITS = 32;

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_LAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_LON = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LON_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_MODE   = 3'd6;

  // Item opcodes.
  localparam logic [1:0] OP_COUNT = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Selection modes.
  localparam logic [1:0] MODE_PICKUP  = 2'd0;
  localparam logic [1:0] MODE_DROPOFF = 2'd1;
  localparam logic [1:0] MODE_BOTH    = 2'd2;

  typedef struct packed {
    logic signed [31:0] origin_lat;
    logic signed [31:0] origin_lon;
    logic [31:0]        lat_scale;
    logic [31:0]        lon_scale;
    logic [9:0]         grid_width;
    logic [9:0]         grid_height;
    logic [1:0]         selection_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    origin_lat:     32'sd0,
    origin_lon:     32'sd0,
    lat_scale:      32'd0,
    lon_scale:      32'd0,
    grid_width:     10'd512,
    grid_height:    10'd512,
    selection_mode: MODE_BOTH
  };

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] pick_lat;
    logic signed [31:0] pickup_lon;
    logic signed [31:0] drop_lat;
    logic signed [31:0] dropoff_lon;
    logic [17:0]        read_index;
  } in_word_t;

  typedef struct packed {
    logic [31:0] max_count;
    logic [31:0] bin_count;
    logic        pickup_counted;
    logic        dropoff_counted;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIFF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_BIN,
    ST_INDEX,
    ST_READ,
    ST_WRITE,
    ST_RD_BIN,
    ST_CLEAR,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic pt;         // 0 pickup point, 1 dropoff point
    logic diff_en;
    logic mul_en;
    logic mul_hi;
    logic bin_en;
    logic index_en;
    logic rd_en;
    logic rd_bin;     // read at the item's read index
    logic wr_en;
    logic clr_en;
    logic clr_start;
    logic emit;
  } gph_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic clr_last;
    logic out_free;
  } gph_stat_t;

endpackage

>>> sv/gph_regs.sv
module gph_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gph_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gph_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output gph_pkg::cfg_t                  cfg
);

  gph_pkg::cfg_t cfg_r;
  gph_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        gph_pkg::REG_ORIGIN_LAT:  cfg_nxt.origin_lat = cfg_wdata;
        gph_pkg::REG_ORIGIN_LON:  cfg_nxt.origin_lon = cfg_wdata;
        gph_pkg::REG_LAT_SCALE:   cfg_nxt.lat_scale = cfg_wdata;
        gph_pkg::REG_LON_SCALE:   cfg_nxt.lon_scale = cfg_wdata;
        gph_pkg::REG_GRID_WIDTH:  cfg_nxt.grid_width = cfg_wdata[9:0];
        gph_pkg::REG_GRID_HEIGHT: cfg_nxt.grid_height = cfg_wdata[9:0];
        gph_pkg::REG_SEL_MODE:    cfg_nxt.selection_mode = cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= gph_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/gph_ctrl.sv
module gph_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_opcode,
  input  logic [1:0]          mode,
  input  gph_pkg::gph_stat_t  stat,
  output logic                in_stall,
  output gph_pkg::gph_cmd_t   cmd
);

  gph_pkg::state_t state_r;
  gph_pkg::state_t state_nxt;
  logic            pt_r;
  logic            pt_nxt;
  logic            do_pick;
  logic            do_drop;

  assign do_pick = (mode == gph_pkg::MODE_PICKUP) || (mode == gph_pkg::MODE_BOTH);
  assign do_drop = (mode == gph_pkg::MODE_DROPOFF) || (mode == gph_pkg::MODE_BOTH);

  always_comb begin
    state_nxt = state_r;
    pt_nxt    = pt_r;
    cmd       = '0;
    cmd.pt    = pt_r;
    in_stall  = 1'b1;
    case (state_r)
      gph_pkg::ST_INIT: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_nxt = gph_pkg::ST_IDLE;
        end
      end
      gph_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (in_opcode)
            gph_pkg::OP_COUNT: begin
              if (do_pick) begin
                pt_nxt    = 1'b0;
                state_nxt = gph_pkg::ST_DIFF;
              end else if (do_drop) begin
                pt_nxt    = 1'b1;
                state_nxt = gph_pkg::ST_DIFF;
              end else begin
                state_nxt = gph_pkg::ST_EMIT;
              end
            end
            gph_pkg::OP_READ: state_nxt = gph_pkg::ST_RD_BIN;
            gph_pkg::OP_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = gph_pkg::ST_CLEAR;
            end
            default: state_nxt = gph_pkg::ST_EMIT;
          endcase
        end
      end
      gph_pkg::ST_DIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = gph_pkg::ST_MUL_LO;
      end
      gph_pkg::ST_MUL_LO: begin
        cmd.mul_en = 1'b1;
        state_nxt  = gph_pkg::ST_MUL_HI;
      end
      gph_pkg::ST_MUL_HI: begin
        cmd.mul_en = 1'b1;
        cmd.mul_hi = 1'b1;
        state_nxt  = gph_pkg::ST_BIN;
      end
      gph_pkg::ST_BIN: begin
        cmd.bin_en = 1'b1;
        state_nxt  = gph_pkg::ST_INDEX;
      end
      gph_pkg::ST_INDEX: begin
        cmd.index_en = 1'b1;
        if (stat.hit) begin
          state_nxt = gph_pkg::ST_READ;
        end else if (!pt_r && (mode == gph_pkg::MODE_BOTH)) begin
          pt_nxt    = 1'b1;
          state_nxt = gph_pkg::ST_DIFF;
        end else begin
          state_nxt = gph_pkg::ST_EMIT;
        end
      end
      gph_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = gph_pkg::ST_WRITE;
      end
      gph_pkg::ST_WRITE: begin
        cmd.wr_en = 1'b1;
        if (!pt_r && (mode == gph_pkg::MODE_BOTH)) begin
          pt_nxt    = 1'b1;
          state_nxt = gph_pkg::ST_DIFF;
        end else begin
          state_nxt = gph_pkg::ST_EMIT;
        end
      end
      gph_pkg::ST_RD_BIN: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_bin = 1'b1;
        state_nxt  = gph_pkg::ST_EMIT;
      end
      gph_pkg::ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_nxt = gph_pkg::ST_EMIT;
        end
      end
      gph_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = gph_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gph_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gph_pkg::ST_INIT;
      pt_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pt_r    <= pt_nxt;
    end
  end

endmodule

>>> sv/gph_dp.sv
module gph_dp #(
  parameter int MAX_WIDTH  = gph_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gph_pkg::DEF_MAX_HEIGHT,
  parameter int COUNT_BITS = gph_pkg::DEF_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gph_pkg::cfg_t       cfg,
  input  gph_pkg::in_word_t   in_data,
  input  logic                out_stall,
  input  gph_pkg::gph_cmd_t   cmd,
  output gph_pkg::gph_stat_t  stat,
  output logic                out_valid,
  output gph_pkg::out_word_t  out_data
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int IDX_PW = ROW_W + WID_W;

  // Item register.
  gph_pkg::in_word_t item_r;
  logic              read_ok_r;

  // Per-axis pipeline: axis 0 is latitude (column), axis 1 is longitude (row).
  logic [32:0] mag_r     [2];
  logic        neg_r     [2];
  logic [48:0] prod_lo_r [2];
  logic [48:0] prod_hi_r [2];
  logic [25:0] quot      [2];
  logic        axis_ok   [2];

  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic              hit_r;
  logic [ADDR_W-1:0] idx_r;
  logic [WID_W-1:0]  w_eff;
  logic [HGT_W-1:0]  h_eff;
  logic [IDX_PW-1:0] row_prod;

  // Bin store.
  logic [COUNT_BITS-1:0] mem [STORE_DEPTH];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic [COUNT_BITS-1:0] inc_val;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  wr_go;
  logic [ADDR_W-1:0]     clr_ptr_r;

  logic [COUNT_BITS-1:0] max_r;
  logic                  pick_r;
  logic                  drop_r;

  gph_pkg::out_word_t    out_data_r;
  logic                  out_valid_r;

  // Grid sizes above the store's limits are clamped.
  assign w_eff = (32'(cfg.grid_width) > 32'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH)
                                                         : WID_W'(cfg.grid_width);
  assign h_eff = (32'(cfg.grid_height) > 32'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT)
                                                           : HGT_W'(cfg.grid_height);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r    <= in_data;
      read_ok_r <= 32'(in_data.read_index) < 32'(STORE_DEPTH);
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic signed [31:0] coord;
    logic signed [31:0] origin;
    logic [31:0]        scale;
    logic [31:0]        size;
    logic signed [32:0] diff;
    logic [64:0]        full;

    if (a == 0) begin : g_lat
      assign coord  = cmd.pt ? item_r.drop_lat : item_r.pick_lat;
      assign origin = cfg.origin_lat;
      assign scale  = cfg.lat_scale;
      assign size   = 32'(w_eff);
    end else begin : g_lon
      assign coord  = cmd.pt ? item_r.dropoff_lon : item_r.pickup_lon;
      assign origin = cfg.origin_lon;
      assign scale  = cfg.lon_scale;
      assign size   = 32'(h_eff);
    end

    assign diff = 33'(coord) - 33'(origin);
    assign full = {prod_hi_r[a], 16'b0} + 65'(prod_lo_r[a]);
    assign quot[a] = full[64:39];
    // A negative offset only lands in bin 0 when its magnitude truncates to 0.
    assign axis_ok[a] = (!neg_r[a] || (quot[a] == '0)) && (32'(quot[a]) < size);

    always_ff @(posedge clk) begin
      if (cmd.diff_en) begin
        neg_r[a] <= diff[32];
        mag_r[a] <= diff[32] ? 33'(-diff) : 33'(diff);
      end
      if (cmd.mul_en) begin
        if (cmd.mul_hi) begin
          prod_hi_r[a] <= mag_r[a] * scale[31:16];
        end else begin
          prod_lo_r[a] <= mag_r[a] * scale[15:0];
        end
      end
    end
  end

  assign row_prod = IDX_PW'(row_r) * IDX_PW'(w_eff);

  always_ff @(posedge clk) begin
    if (cmd.bin_en) begin
      hit_r <= axis_ok[0] && axis_ok[1];
      col_r <= COL_W'(quot[0]);
      row_r <= ROW_W'(quot[1]);
    end
    if (cmd.index_en) begin
      idx_r <= ADDR_W'(row_prod) + ADDR_W'(col_r);
    end
  end

  // Memory access.
  assign rd_addr = cmd.rd_bin ? ADDR_W'(item_r.read_index) : idx_r;
  assign inc_val = (rd_data_r == '1) ? rd_data_r : rd_data_r + 1'b1;
  assign wr_go   = cmd.wr_en || cmd.clr_en;
  assign wr_addr = cmd.clr_en ? clr_ptr_r : idx_r;
  assign wr_data = cmd.clr_en ? '0 : inc_val;

  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign stat.clr_last = (clr_ptr_r == ADDR_W'(STORE_DEPTH - 1));
  assign stat.hit      = hit_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
      max_r     <= '0;
    end else begin
      if (cmd.clr_en) begin
        clr_ptr_r <= stat.clr_last ? '0 : clr_ptr_r + 1'b1;
      end
      if (cmd.clr_start) begin
        max_r <= '0;
      end else if (cmd.wr_en && (inc_val > max_r)) begin
        max_r <= inc_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      pick_r <= 1'b0;
      drop_r <= 1'b0;
    end else if (cmd.wr_en) begin
      if (cmd.pt) begin
        drop_r <= 1'b1;
      end else begin
        pick_r <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.max_count <= 32'(max_r);
      out_data_r.bin_count <= ((item_r.opcode == gph_pkg::OP_READ) && read_ok_r)
                              ? 32'(rd_data_r) : 32'd0;
      out_data_r.pickup_counted  <= pick_r;
      out_data_r.dropoff_counted <= drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/geo_point_2d_histogram.sv
// Two-dimensional histogram of trip endpoints. Each count word carries a
// pickup and a dropoff point in signed Q8.23 degrees; depending on the
// selection mode one, both or none of the points are mapped to a bin, column from
// latitude and row from longitude, by truncating (coord - origin) * scale
// toward zero with the scale in unsigned Q16.16 bins per degree. Points
// outside the grid are dropped, a bin counter saturates at its all-ones
// value, and a running maximum over all bins is reported with every result.
// A read word returns the bin at read_index, and a clear word zeroes every
// bin and the maximum. Each accepted word gives exactly one result word.
// A count word is taken in the idle state, and for each selected point the
// steps are subtract, two 33x16 partial products, bin check, index multiply,
// store read and store write; for a point that falls outside the grid the
// store read and write are skipped. The result is emitted after the last
// point. A read word reads the bin store at read_index. A clear word walks
// every entry of the bin store through its single write port, one entry a
// cycle. The same sweep runs right after reset, and in_stall stays high until
// it ends, while configuration writes are taken at any time. The result
// register lets the next word be accepted while a finished result still
// waits on out_stall. Configure only while idle.
module geo_point_2d_histogram #(
  parameter int MAX_WIDTH  = gph_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gph_pkg::DEF_MAX_HEIGHT,
  parameter int COUNT_BITS = gph_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  gph_pkg::in_word_t              in_data,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output gph_pkg::out_word_t             out_data,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [gph_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gph_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  gph_pkg::cfg_t      cfg;
  gph_pkg::gph_cmd_t  cmd;
  gph_pkg::gph_stat_t stat;

  // Register file for the region, scale, grid size and selection mode.
  gph_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The controller sequences each word: the binning steps for each point,
  // the read-modify-write of the bin, the clear sweep and the result hand-off.
  gph_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .mode      (cfg.selection_mode),
    .stat      (stat),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  // The datapath holds the word, the per-axis multipliers, the bin store,
  // the running maximum and the result register.
  gph_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
